[hw/rtl/bhpq_pkg.sv]
`default_nettype none
package bhpq_pkg;

   localparam int DEPTH        = 64;
   localparam int PAYLOAD_BITS = 16;
   localparam int ADDR_BITS    = $clog2(DEPTH);
   localparam int CNT_BITS     = 7;
   localparam int ENTRY_BITS   = 8 + PAYLOAD_BITS;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [0:0] CMD_INSERT  = 1'b0;
   localparam logic [0:0] CMD_EXTRACT = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam logic [0:0] CSR_ORDER_MODE = 1'b0;
   localparam logic [0:0] CSR_CAPACITY   = 1'b1;

   typedef struct packed {
      logic [0:0]  cmd;
      logic signed [7:0] new_score;
      logic [15:0] new_payload;
   } req_type;

   typedef struct packed {
      logic [15:0] out_payload;
      logic signed [7:0] out_score;
      logic [1:0]  op_status;
      logic [6:0]  entry_count;
      logic signed [7:0] top_score;
      logic [15:0] top_payload;
   } rsp_type;

   typedef struct packed {
      logic [0:0]  cmd;
      logic [1:0]  status;
      logic signed [7:0] score;
      logic [PAYLOAD_BITS-1:0] payload;
   } op_type;

   typedef struct packed {
      logic signed [7:0] score;
      logic [PAYLOAD_BITS-1:0] payload;
   } entry_type;

endpackage
`default_nettype wire

[hw/rtl/bhpq_ram.sv]
`default_nettype none
module bhpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[hw/rtl/bhpq_front.sv]
`default_nettype none
module bhpq_front import bhpq_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   input  wire req_type       req_data,
   input  wire logic [6:0]    cap_limit,
   input  wire logic          q_pop,
   output      logic          q_valid,
   output      op_type        q_data
);
   // Tracks the committed count so items are classified without waiting on the back end.
   op_type         q_ff [QUEUE_DEPTH];
   logic [1:0]     cnt_q_ff, cnt_q_in;
   logic           wp_ff, wp_in, rp_ff, rp_in;
   logic [CNT_BITS-1:0] held_ff, held_in;
   logic [CNT_BITS-1:0] cap;
   logic           push;
   op_type         op;

   assign cap       = (cap_limit > CNT_BITS'(DEPTH)) ? CNT_BITS'(DEPTH) : cap_limit;
   assign req_ready = (cnt_q_ff != 2'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_q_ff != 2'd0);
   assign q_data    = q_ff[rp_ff];

   always_comb begin
      op.cmd     = req_data.cmd;
      op.score   = req_data.new_score;
      op.payload = req_data.new_payload[PAYLOAD_BITS-1:0];
      op.status  = STATUS_DONE;
      held_in    = held_ff;
      if (req_data.cmd == CMD_INSERT) begin
         if (held_ff >= cap) begin
            op.status = STATUS_FULL;
         end else if (push) begin
            held_in = held_ff + CNT_BITS'(1);
         end
      end else begin
         if (held_ff == '0) begin
            op.status = STATUS_EMPTY;
         end else if (push) begin
            held_in = held_ff - CNT_BITS'(1);
         end
      end
      if (!push) begin
         held_in = held_ff;
      end
      wp_in    = push ? ~wp_ff : wp_ff;
      rp_in    = q_pop ? ~rp_ff : rp_ff;
      cnt_q_in = cnt_q_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_q_ff <= '0;
         wp_ff    <= 1'b0;
         rp_ff    <= 1'b0;
         held_ff  <= '0;
      end else begin
         cnt_q_ff <= cnt_q_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         held_ff  <= held_in;
      end
      if (push) begin
         q_ff[wp_ff] <= op;
      end
   end

   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset) held_ff <= CNT_BITS'(DEPTH))
      else $error("count above depth");
   assert property (@(posedge clock) disable iff (reset)
      cnt_q_ff <= 2'(QUEUE_DEPTH)) else $error("queue overflow");
endmodule
`default_nettype wire

[hw/rtl/bhpq_back.sv]
`default_nettype none
module bhpq_back import bhpq_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     order_mode,
   input  wire logic     q_valid,
   input  wire op_type   q_data,
   output      logic     q_pop,
   output      logic     rsp_valid,
   input  wire logic     rsp_ready,
   output      rsp_type  rsp_data
);
   typedef enum logic [3:0] {
      S_IDLE, S_UP_CMP, S_PLACE, S_DN_LAST, S_DN_CUR, S_DN_NEXT,
      S_DN_LEFT, S_DN_CMP, S_TOP_RD, S_TOP_WT
   } state_type;

   state_type            state_ff;
   logic [1:0]           status_ff;
   logic [CNT_BITS-1:0]  held_ff;
   logic [ADDR_BITS-1:0] pos_ff;
   entry_type            cur_ff, lft_ff, out_ff;
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;

   logic                 wr_en;
   logic [ADDR_BITS-1:0] wr_addr, rd_addr;
   entry_type            wr_data, rd_data;

   logic [CNT_BITS:0]    lidx, ridx;
   logic                 ok_l, ok_r;
   logic [ADDR_BITS-1:0] par, gpar;
   logic                 up_win, l_win, r_win;

   function automatic logic beats(input logic m, input logic signed [7:0] a,
                                  input logic signed [7:0] b);
      return m ? (a < b) : (a > b);
   endfunction

   bhpq_ram #(.WIDTH(ENTRY_BITS), .DEPTH(DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // the moving entry stays in cur_ff; the hole at pos_ff is filled last
   assign lidx   = {1'b0, pos_ff, 1'b1};
   assign ridx   = {1'b0, pos_ff, 1'b0} + (CNT_BITS+1)'(2);
   assign ok_l   = lidx < {1'b0, held_ff};
   assign ok_r   = ridx < {1'b0, held_ff};
   assign par    = (pos_ff - ADDR_BITS'(1)) >> 1;
   assign gpar   = (par - ADDR_BITS'(1)) >> 1;
   assign up_win = beats(order_mode, cur_ff.score, rd_data.score);
   assign l_win  = beats(order_mode, lft_ff.score, cur_ff.score);
   assign r_win  = ok_r && beats(order_mode, rd_data.score,
                                 l_win ? lft_ff.score : cur_ff.score);

   assign q_pop     = (state_ff == S_IDLE) && q_valid && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = cur_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_pop && q_data.status == STATUS_DONE && q_data.cmd == CMD_INSERT) begin
               rd_addr = ADDR_BITS'((held_ff - CNT_BITS'(1)) >> 1);
            end
         end
         S_UP_CMP: begin
            rd_addr = gpar;
            if (up_win) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
            end
         end
         S_PLACE:   wr_en = 1'b1;
         S_DN_LAST: rd_addr = ADDR_BITS'(held_ff);
         S_DN_CUR, S_DN_NEXT: rd_addr = lidx[ADDR_BITS-1:0];
         S_DN_LEFT: rd_addr = ridx[ADDR_BITS-1:0];
         S_DN_CMP: begin
            if (r_win) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
            end else if (l_win) begin
               wr_en   = 1'b1;
               wr_data = lft_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (rsp_valid_ff && rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (q_pop) begin
                  status_ff <= q_data.status;
                  out_ff    <= '0;
                  if (q_data.status != STATUS_DONE) begin
                     state_ff <= S_TOP_RD;
                  end else if (q_data.cmd == CMD_INSERT) begin
                     cur_ff   <= '{score: q_data.score, payload: q_data.payload};
                     pos_ff   <= ADDR_BITS'(held_ff);
                     held_ff  <= held_ff + CNT_BITS'(1);
                     state_ff <= (held_ff == '0) ? S_PLACE : S_UP_CMP;
                  end else begin
                     pos_ff   <= '0;
                     held_ff  <= held_ff - CNT_BITS'(1);
                     state_ff <= S_DN_LAST;
                  end
               end
            end
            S_UP_CMP: begin
               if (up_win) begin
                  pos_ff   <= par;
                  state_ff <= (par == '0) ? S_PLACE : S_UP_CMP;
               end else begin
                  state_ff <= S_PLACE;
               end
            end
            S_PLACE: state_ff <= S_TOP_RD;
            S_DN_LAST: begin
               out_ff   <= rd_data;
               state_ff <= (held_ff == '0) ? S_TOP_RD : S_DN_CUR;
            end
            S_DN_CUR: begin
               cur_ff   <= rd_data;
               state_ff <= ok_l ? S_DN_LEFT : S_PLACE;
            end
            S_DN_NEXT: state_ff <= ok_l ? S_DN_LEFT : S_PLACE;
            S_DN_LEFT: begin
               lft_ff   <= rd_data;
               state_ff <= S_DN_CMP;
            end
            S_DN_CMP: begin
               if (r_win) begin
                  pos_ff   <= ridx[ADDR_BITS-1:0];
                  state_ff <= S_DN_NEXT;
               end else if (l_win) begin
                  pos_ff   <= lidx[ADDR_BITS-1:0];
                  state_ff <= S_DN_NEXT;
               end else begin
                  state_ff <= S_PLACE;
               end
            end
            S_TOP_RD: state_ff <= S_TOP_WT;
            S_TOP_WT: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_TOP_WT) begin
         rsp_ff.out_payload <= 16'(out_ff.payload);
         rsp_ff.out_score   <= out_ff.score;
         rsp_ff.op_status   <= status_ff;
         rsp_ff.entry_count <= held_ff;
         rsp_ff.top_score   <= (held_ff != '0) ? rd_data.score : '0;
         rsp_ff.top_payload <= (held_ff != '0) ? 16'(rd_data.payload) : '0;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data)) else $error("result changed");
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !rsp_valid) else $error("pop over pending result");
   assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_BITS'(DEPTH)) else $error("heap overflow");
endmodule
`default_nettype wire

[hw/rtl/binary_heap_priority_queue.sv]
// channel | dir | payload
// req     | in  | cmd, new_score, new_payload
// rsp     | out | out_payload, out_score, op_status, entry_count, top_*
// csr     | in  | index 0 order_mode, 1 capacity_limit
// An item is registered in the queue; the sift engine then takes it when idle.
// After acceptance a refused request only reads the top entry; an insert compares
// with parents on the way up; an extract takes the root and sifts the last entry
// down level by level until a compare or a leaf stops it. One RAM read per step.
// A pending result holds the engine; the two-entry queue keeps accepting until full.
// Synchronous reset empties the heap; RAM contents are not cleared.
`default_nettype none
module binary_heap_priority_queue import bhpq_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire req_type    req_data,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      rsp_type    rsp_data,
   input  wire logic       csr_valid,
   output      logic       csr_ready,
   input  wire logic [0:0] csr_index,
   input  wire logic [6:0] csr_data
);
   logic   order_ff;
   logic [6:0] cap_ff;
   logic   q_valid, q_pop;
   op_type q_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 1'b0;
         cap_ff   <= 7'd64;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ORDER_MODE: order_ff <= csr_data[0];
            CSR_CAPACITY:   cap_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   bhpq_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .cap_limit(cap_ff), .q_pop, .q_valid, .q_data
   );

   bhpq_back u_back (
      .clock, .reset, .order_mode(order_ff), .q_valid, .q_data, .q_pop,
      .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule
`default_nettype wire
